/* rtl/core/sd_spi_init_sequencer_core_defines.svh */
// Assertion macros used by the SD SPI init sequencer state machine.
`ifndef SD_SPI_INIT_SEQUENCER_CORE_DEFINES_SVH
`define SD_SPI_INIT_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define SDI_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define SDI_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define SDI_ASSERT(lbl, ck, rstn, prop, msg)
`define SDI_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

/* rtl/core/sdinit_pkg.sv */
// Types and constants of the SD SPI init sequencer.
`default_nettype none
package sdinit_pkg;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_RESP   = 2'd1,
		OP_NORESP = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [8:0] {
		PH_IDLE  = 9'b0_0000_0001,
		PH_CMD0  = 9'b0_0000_0010,
		PH_CMD8  = 9'b0_0000_0100,
		PH_HCS   = 9'b0_0000_1000,
		PH_OCR   = 9'b0_0001_0000,
		PH_PLAIN = 9'b0_0010_0000,
		PH_CMD1  = 9'b0_0100_0000,
		PH_CMD16 = 9'b0_1000_0000,
		PH_CMD59 = 9'b1_0000_0000
	} phase_t;

	// card version codes
	localparam logic [2:0] VER_UNKNOWN  = 3'd0;
	localparam logic [2:0] VER_V1       = 3'd1;
	localparam logic [2:0] VER_V2_BYTE  = 3'd2;
	localparam logic [2:0] VER_V2_BLOCK = 3'd3;
	localparam logic [2:0] VER_V3       = 3'd4;

	// command indexes
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_OP   = 6'd1;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
	localparam logic [5:0] CMD_APP_OP    = 6'd41;
	localparam logic [5:0] CMD_READ_OCR  = 6'd58;
	localparam logic [5:0] CMD_CRC_ON    = 6'd59;

	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
	localparam logic [31:0] ARG_BLOCKLEN = 32'd512;
	localparam logic [7:0]  R7_CHECK     = 8'hAA;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC     = 1'b1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 16'd1000;

	typedef struct packed {
		op_t        operation;
		logic       r1_idle;
		logic       r1_error;
		logic [7:0] r7_pattern;
		logic       r7_voltage_ok;
		logic       ocr_ccs;
		logic       prefix_failed;
	} item_t;

	typedef struct packed {
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic        is_app_cmd;
		logic        finished;
		logic        success;
		logic [2:0]  version;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/sdinit_in_reg.sv */
// Input register stage: holds one accepted event for the sequencer.
`default_nettype none
module sdinit_in_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  sdinit_pkg::item_t   item_in,
	input  wire                 advance,
	output logic                valid_s1,
	output sdinit_pkg::item_t   item_s1
);
	import sdinit_pkg::*;

	logic accept;

	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sdinit_fsm.sv */
// Init sequence state machine: phase, tick counter and card version update.
`default_nettype none
`include "sd_spi_init_sequencer_core_defines.svh"
module sdinit_fsm #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid_s1,
	input  sdinit_pkg::item_t   item_s1,
	input  wire [15:0]          timeout_ticks,
	input  wire                 crc_enable,
	input  wire                 out_ready,
	output logic                advance,
	output logic                has_result,
	output sdinit_pkg::result_t result
);
	import sdinit_pkg::*;

	localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] loop_ticks_q, loop_ticks_d;
	logic [2:0]            version_q, version_d;
	logic                  got, expired, fire;

	function automatic result_t mk_cmd(logic [5:0] idx, logic [31:0] arg, logic app,
			logic [2:0] ver);
		result_t r;
		r.cmd_index    = idx;
		r.cmd_argument = arg;
		r.is_app_cmd   = app;
		r.finished     = 1'b0;
		r.success      = 1'b0;
		r.version      = ver;
		return r;
	endfunction

	function automatic result_t mk_done(logic ok, logic [2:0] ver);
		result_t r;
		r.cmd_index    = CMD_GO_IDLE;
		r.cmd_argument = '0;
		r.is_app_cmd   = 1'b0;
		r.finished     = 1'b1;
		r.success      = ok;
		r.version      = ver;
		return r;
	endfunction

	assign got     = (item_s1.operation == OP_RESP);
	assign expired = CMP_W'(loop_ticks_q) >= CMP_W'(timeout_ticks);

	always_comb begin
		phase_d      = phase_q;
		loop_ticks_d = loop_ticks_q;
		version_d    = version_q;
		has_result   = 1'b0;
		result       = mk_done(1'b0, version_q);
		if (item_s1.operation == OP_START) begin
			version_d    = VER_UNKNOWN;
			loop_ticks_d = '0;
			phase_d      = PH_CMD0;
			has_result   = 1'b1;
			result       = mk_cmd(CMD_GO_IDLE, '0, 1'b0, VER_UNKNOWN);
		end else if (item_s1.operation == OP_TICK) begin
			if (loop_ticks_q != '1) begin
				loop_ticks_d = loop_ticks_q + 1'b1;
			end
		end else begin
			has_result = 1'b1;
			unique case (phase_q)
				PH_CMD0: begin
					if (!got || item_s1.r1_error) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_CMD8;
						result  = mk_cmd(CMD_IF_COND, ARG_IF_COND, 1'b0, version_q);
					end
				end
				PH_CMD8: begin
					if (!got) begin
						phase_d      = PH_PLAIN;
						loop_ticks_d = '0;
						result       = mk_cmd(CMD_APP_OP, '0, 1'b1, version_q);
					end else if (item_s1.r7_pattern == R7_CHECK && item_s1.r7_voltage_ok) begin
						phase_d      = PH_HCS;
						loop_ticks_d = '0;
						result       = mk_cmd(CMD_APP_OP, ARG_HCS, 1'b1, version_q);
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_HCS: begin
					if (item_s1.prefix_failed || !got || item_s1.r1_error) begin
						phase_d = PH_IDLE;
					end else if (item_s1.r1_idle) begin
						if (expired) begin
							phase_d = PH_IDLE;
						end else begin
							result = mk_cmd(CMD_APP_OP, ARG_HCS, 1'b1, version_q);
						end
					end else begin
						phase_d = PH_OCR;
						result  = mk_cmd(CMD_READ_OCR, '0, 1'b0, version_q);
					end
				end
				PH_OCR: begin
					if (!got || item_s1.r1_error) begin
						phase_d = PH_IDLE;
					end else if (item_s1.ocr_ccs) begin
						// block-addressed card skips the block length command
						version_d = VER_V2_BLOCK;
						phase_d   = PH_CMD59;
						result    = mk_cmd(CMD_CRC_ON, 32'(crc_enable), 1'b0, VER_V2_BLOCK);
					end else begin
						version_d = VER_V2_BYTE;
						phase_d   = PH_CMD16;
						result    = mk_cmd(CMD_BLOCKLEN, ARG_BLOCKLEN, 1'b0, VER_V2_BYTE);
					end
				end
				PH_PLAIN: begin
					if (item_s1.prefix_failed) begin
						phase_d = PH_IDLE;
					end else if (!got || item_s1.r1_error || (item_s1.r1_idle && expired)) begin
						phase_d      = PH_CMD1;
						loop_ticks_d = '0;
						result       = mk_cmd(CMD_SEND_OP, '0, 1'b0, version_q);
					end else if (item_s1.r1_idle) begin
						result = mk_cmd(CMD_APP_OP, '0, 1'b1, version_q);
					end else begin
						version_d = VER_V1;
						phase_d   = PH_CMD16;
						result    = mk_cmd(CMD_BLOCKLEN, ARG_BLOCKLEN, 1'b0, VER_V1);
					end
				end
				PH_CMD1: begin
					if (!got || item_s1.r1_error || (item_s1.r1_idle && expired)) begin
						phase_d = PH_IDLE;
					end else if (item_s1.r1_idle) begin
						result = mk_cmd(CMD_SEND_OP, '0, 1'b0, version_q);
					end else begin
						version_d = VER_V3;
						phase_d   = PH_CMD16;
						result    = mk_cmd(CMD_BLOCKLEN, ARG_BLOCKLEN, 1'b0, VER_V3);
					end
				end
				PH_CMD16: begin
					if (!got || item_s1.r1_error) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_CMD59;
						result  = mk_cmd(CMD_CRC_ON, 32'(crc_enable), 1'b0, version_q);
					end
				end
				PH_CMD59: begin
					phase_d = PH_IDLE;
					result  = mk_done(got && !item_s1.r1_error, version_q);
				end
				default: begin
					// idle or a corrupt code: answers are dropped
					phase_d    = PH_IDLE;
					has_result = 1'b0;
				end
			endcase
		end
	end

	// an event without a result never waits on the output side
	assign advance = out_ready || !has_result;
	assign fire    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			loop_ticks_q <= '0;
			version_q    <= VER_UNKNOWN;
		end else if (fire) begin
			phase_q      <= phase_d;
			loop_ticks_q <= loop_ticks_d;
			version_q    <= version_d;
		end
	end

	`SDI_ASSERT(a_tick_silent, clk, arst_n, (valid_s1 && item_s1.operation == OP_TICK) |-> !has_result, "tick produced a transaction")
	`SDI_ASSERT(a_start_cmd0, clk, arst_n, (fire && item_s1.operation == OP_START) |=> (phase_q == PH_CMD0 && version_q == VER_UNKNOWN && loop_ticks_q == '0), "start did not restart the sequence")
	`SDI_ASSERT(a_done_idle, clk, arst_n, (fire && has_result && result.finished) |=> (phase_q == PH_IDLE), "finished result left the sequence running")
	`SDI_ASSERT_ALWAYS(a_reset_hold, clk, !arst_n |=> (phase_q == PH_IDLE && loop_ticks_q == '0), "state not cleared by reset")

endmodule
`default_nettype wire

/* rtl/core/sdinit_out_reg.sv */
// Result register: holds one result transaction until it is taken.
`default_nettype none
module sdinit_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  sdinit_pkg::result_t result_in,
	input  wire                 result_stall,
	output logic                result_valid,
	output logic                out_ready,
	output sdinit_pkg::result_t result_q
);
	import sdinit_pkg::*;

	assign out_ready = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_ready) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_ready) begin
			result_q <= result_in;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sd_spi_init_sequencer_core.sv */
// Top level of the SD card SPI-mode initialization sequencer.
// Takes one event transaction per clock (start, response, no response, tick) and
// answers with at most one result transaction: the next command to send, or a finished
// flag with success and card version. An event is registered on acceptance, decoded by
// the state machine in the next cycle and its result registered; throughput is one
// event per cycle, and only a stalled result register holds the input side back.
// Configuration writes take effect on the clock edge they occur.
`default_nettype none
module sd_spi_init_sequencer_core #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire [sdinit_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [sdinit_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                  item_valid,
	output logic                                 item_stall,
	input  wire [1:0]                            operation,
	input  wire                                  r1_idle,
	input  wire                                  r1_error,
	input  wire [7:0]                            r7_pattern,
	input  wire                                  r7_voltage_ok,
	input  wire                                  ocr_ccs,
	input  wire                                  prefix_failed,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic [5:0]                           cmd_index,
	output logic [31:0]                          cmd_argument,
	output logic                                 is_app_cmd,
	output logic                                 finished,
	output logic                                 success,
	output logic [2:0]                           version
);
	import sdinit_pkg::*;

	logic [15:0] timeout_q;
	logic        crc_q;
	item_t       item_in, item_s1;
	logic        valid_s1, advance, has_result, out_ready;
	result_t     result_d, result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			crc_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_CRC:     crc_q     <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		item_in.operation     = op_t'(operation);
		item_in.r1_idle       = r1_idle;
		item_in.r1_error      = r1_error;
		item_in.r7_pattern    = r7_pattern;
		item_in.r7_voltage_ok = r7_voltage_ok;
		item_in.ocr_ccs       = ocr_ccs;
		item_in.prefix_failed = prefix_failed;
	end

	sdinit_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	sdinit_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.timeout_ticks (timeout_q),
		.crc_enable    (crc_q),
		.out_ready     (out_ready),
		.advance       (advance),
		.has_result    (has_result),
		.result        (result_d)
	);

	sdinit_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1 && has_result),
		.result_in    (result_d),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_ready    (out_ready),
		.result_q     (result_q)
	);

	assign cmd_index    = result_q.cmd_index;
	assign cmd_argument = result_q.cmd_argument;
	assign is_app_cmd   = result_q.is_app_cmd;
	assign finished     = result_q.finished;
	assign success      = result_q.success;
	assign version      = result_q.version;

endmodule
`default_nettype wire
